FILE: src/drc_pkg.sv
// shared types, constants and codes for the dirty rectangle coalescer
`timescale 1ns / 1ps
package drc_pkg;

  localparam int COORD_BITS      = 16;
  localparam int MAX_REGIONS_DEF = 64;
  localparam int OPT_THRESHOLD   = 50;
  localparam int MIN_AREA        = 100;
  localparam int CNT_OUT_W       = 7;
  localparam int TIME_W          = 32;
  localparam int IVL_W           = 10;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 10;
  localparam logic [IVL_W-1:0] IVL_RESET = IVL_W'(22);

  typedef enum logic [1:0] {
    OP_MARK     = 2'd0,
    OP_OPTIMIZE = 2'd1,
    OP_FLUSH    = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    K_STORED    = 3'd0,
    K_IGNORED   = 3'd1,
    K_DROPPED   = 3'd2,
    K_OPTIMIZED = 3'd3,
    K_HELD      = 3'd4,
    K_EMPTY     = 3'd5,
    K_REGION    = 3'd6
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PR_EN  = 2'd0,
    REG_BAT_EN = 2'd1,
    REG_IVL    = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_O_RDA,
    S_O_LDA,
    S_O_RDB,
    S_O_CMP,
    S_SH_RD,
    S_SH_WR,
    S_C_RD,
    S_C_CHK,
    S_DONE,
    S_F_RD,
    S_F_OUT
  } state_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic signed [COORD_BITS-1:0] x2;
    logic signed [COORD_BITS-1:0] y2;
  } rect_t;

  typedef struct packed {
    logic [1:0]                   op;
    logic signed [COORD_BITS-1:0] left_x;
    logic signed [COORD_BITS-1:0] top_y;
    logic signed [COORD_BITS-1:0] right_x;
    logic signed [COORD_BITS-1:0] bottom_y;
    logic [TIME_W-1:0]            now_ms;
  } in_t;

  typedef struct packed {
    logic [2:0]                   kind;
    logic signed [COORD_BITS-1:0] out_left_x;
    logic signed [COORD_BITS-1:0] out_top_y;
    logic signed [COORD_BITS-1:0] out_right_x;
    logic signed [COORD_BITS-1:0] out_bottom_y;
    logic [CNT_OUT_W-1:0]         stored_count;
    logic [TIME_W-1:0]            marked_total;
    logic                         last;
  } out_t;

  typedef struct packed {
    logic             pr_en;
    logic             bat_en;
    logic [IVL_W-1:0] ivl;
  } cfg_t;

  typedef struct packed {
    logic  overlap;
    logic  tiny;
    rect_t bbox;
  } geom_t;

endpackage

FILE: src/drc_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module drc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/drc_geom.sv
// shared geometry unit: overlap test, bounding box and small area test
`timescale 1ns / 1ps
module drc_geom (
  input  drc_pkg::rect_t a_i,
  input  drc_pkg::rect_t b_i,
  output drc_pkg::geom_t res_o
);

  localparam int WW = drc_pkg::COORD_BITS + 2;

  logic signed [WW-1:0] w, h;
  logic [WW-1:0]        aw, ah;
  logic [13:0]          prod;

  // overlap and bounding box of a and b
  always_comb begin
    res_o.overlap = !((a_i.x2 < b_i.x1) || (b_i.x2 < a_i.x1) ||
                      (a_i.y2 < b_i.y1) || (b_i.y2 < a_i.y1));
    res_o.bbox.x1 = (b_i.x1 < a_i.x1) ? b_i.x1 : a_i.x1;
    res_o.bbox.y1 = (b_i.y1 < a_i.y1) ? b_i.y1 : a_i.y1;
    res_o.bbox.x2 = (b_i.x2 > a_i.x2) ? b_i.x2 : a_i.x2;
    res_o.bbox.y2 = (b_i.y2 > a_i.y2) ? b_i.y2 : a_i.y2;
  end

  // exact signed area of b below the minimum
  always_comb begin
    w    = WW'(b_i.x2) - WW'(b_i.x1) + WW'(1);
    h    = WW'(b_i.y2) - WW'(b_i.y1) + WW'(1);
    aw   = w[WW-1] ? WW'(-w) : WW'(w);
    ah   = h[WW-1] ? WW'(-h) : WW'(h);
    prod = aw[6:0] * ah[6:0];
    if (w == '0 || h == '0) begin
      res_o.tiny = 1'b1;
    end else if (w[WW-1] != h[WW-1]) begin
      res_o.tiny = 1'b1;
    end else if (aw >= WW'(drc_pkg::MIN_AREA) || ah >= WW'(drc_pkg::MIN_AREA)) begin
      res_o.tiny = 1'b0;
    end else begin
      res_o.tiny = prod < 14'(drc_pkg::MIN_AREA);
    end
  end

endmodule

FILE: src/drc_seq.sv
// sequencer: mark, optimize pass over the store and flush emission
`timescale 1ns / 1ps
module drc_seq #(
  parameter int MAX_REGIONS = drc_pkg::MAX_REGIONS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  drc_pkg::cfg_t                  cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  drc_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output drc_pkg::out_t                  out_data_o,
  output logic                           ram_we_o,
  output logic [$clog2(MAX_REGIONS)-1:0] ram_waddr_o,
  output drc_pkg::rect_t                 ram_wdata_o,
  output logic [$clog2(MAX_REGIONS)-1:0] ram_raddr_o,
  input  drc_pkg::rect_t                 ram_rdata_i
);

  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int AW = $clog2(MAX_REGIONS);

  drc_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d, i_q, i_d, j_q, j_d;
  logic [drc_pkg::TIME_W-1:0] total_q, total_d, lft_q, lft_d;
  logic            mark_q, mark_d;
  drc_pkg::rect_t  a_q, a_d;
  logic            out_valid_q, out_valid_d;
  drc_pkg::out_t   out_q, out_d;
  logic            out_free, acc, post;
  drc_pkg::out_t   post_w;
  drc_pkg::geom_t  geo;
  drc_pkg::rect_t  in_rect;
  logic [drc_pkg::TIME_W-1:0] elapsed;

  drc_geom u_geom (
    .a_i  (a_q),
    .b_i  (ram_rdata_i),
    .res_o(geo)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !(state_q == drc_pkg::S_IDLE && out_free);
  assign acc         = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign elapsed     = in_data_i.now_ms - lft_q;

  always_comb begin
    in_rect.x1 = in_data_i.left_x;
    in_rect.y1 = in_data_i.top_y;
    in_rect.x2 = in_data_i.right_x;
    in_rect.y2 = in_data_i.bottom_y;
  end

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= drc_pkg::S_IDLE;
      cnt_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      total_q     <= '0;
      lft_q       <= '0;
      mark_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      i_q         <= i_d;
      j_q         <= j_d;
      total_q     <= total_d;
      lft_q       <= lft_d;
      mark_q      <= mark_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    out_q <= out_d;
  end

  // next state, store access and result words
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    total_d     = total_q;
    lft_d       = lft_q;
    mark_d      = mark_q;
    a_d         = a_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = i_q[AW-1:0];
    ram_wdata_o = ram_rdata_i;
    ram_raddr_o = i_q[AW-1:0];
    post        = 1'b0;
    post_w      = '0;
    post_w.stored_count = drc_pkg::CNT_OUT_W'(cnt_q);
    post_w.marked_total = total_q;
    post_w.last         = 1'b1;

    case (state_q)
      drc_pkg::S_IDLE: begin
        if (acc) begin
          post = 1'b1;
          post_w.kind = drc_pkg::K_IGNORED;
          case (in_data_i.op)
            drc_pkg::OP_MARK: begin
              if (!cfg_i.pr_en) begin
                post_w.kind = drc_pkg::K_IGNORED;
              end else if (cnt_q >= CW'(MAX_REGIONS)) begin
                post_w.kind = drc_pkg::K_DROPPED;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = cnt_q[AW-1:0];
                ram_wdata_o = in_rect;
                cnt_d       = cnt_q + CW'(1);
                total_d     = total_q + 1'b1;
                post_w.kind = drc_pkg::K_STORED;
                post_w.stored_count = drc_pkg::CNT_OUT_W'(cnt_d);
                post_w.marked_total = total_d;
                if (cnt_d > CW'(drc_pkg::OPT_THRESHOLD)) begin
                  post    = 1'b0;
                  mark_d  = 1'b1;
                  i_d     = '0;
                  state_d = drc_pkg::S_O_RDA;
                end
              end
            end
            drc_pkg::OP_OPTIMIZE: begin
              post    = 1'b0;
              mark_d  = 1'b0;
              i_d     = '0;
              state_d = drc_pkg::S_O_RDA;
            end
            drc_pkg::OP_FLUSH: begin
              if (cnt_q == '0) begin
                post_w.kind = drc_pkg::K_EMPTY;
              end else if (cfg_i.bat_en &&
                           elapsed < drc_pkg::TIME_W'(cfg_i.ivl)) begin
                post_w.kind = drc_pkg::K_HELD;
              end else begin
                post    = 1'b0;
                j_d     = cnt_q;
                cnt_d   = '0;
                lft_d   = in_data_i.now_ms;
                i_d     = '0;
                state_d = drc_pkg::S_F_RD;
              end
            end
            default: begin
              post_w.kind = drc_pkg::K_IGNORED;
            end
          endcase
        end
      end
      // merge search: fetch entry i
      drc_pkg::S_O_RDA: begin
        if (i_q + CW'(1) >= cnt_q) begin
          i_d     = '0;
          j_d     = '0;
          state_d = drc_pkg::S_C_RD;
        end else begin
          ram_raddr_o = i_q[AW-1:0];
          state_d     = drc_pkg::S_O_LDA;
        end
      end
      drc_pkg::S_O_LDA: begin
        a_d     = ram_rdata_i;
        j_d     = i_q + CW'(1);
        state_d = drc_pkg::S_O_RDB;
      end
      // fetch candidate j
      drc_pkg::S_O_RDB: begin
        if (j_q >= cnt_q) begin
          i_d     = i_q + CW'(1);
          state_d = drc_pkg::S_O_RDA;
        end else begin
          ram_raddr_o = j_q[AW-1:0];
          state_d     = drc_pkg::S_O_CMP;
        end
      end
      drc_pkg::S_O_CMP: begin
        if (geo.overlap) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = i_q[AW-1:0];
          ram_wdata_o = geo.bbox;
          state_d     = drc_pkg::S_SH_RD;
        end else begin
          j_d     = j_q + CW'(1);
          state_d = drc_pkg::S_O_RDB;
        end
      end
      // close the gap left by entry j
      drc_pkg::S_SH_RD: begin
        if (j_q + CW'(1) >= cnt_q) begin
          cnt_d   = cnt_q - CW'(1);
          i_d     = '0;
          state_d = drc_pkg::S_O_RDA;
        end else begin
          ram_raddr_o = AW'(j_q + CW'(1));
          state_d     = drc_pkg::S_SH_WR;
        end
      end
      drc_pkg::S_SH_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = j_q[AW-1:0];
        ram_wdata_o = ram_rdata_i;
        j_d         = j_q + CW'(1);
        state_d     = drc_pkg::S_SH_RD;
      end
      // compaction: i reads, j writes kept entries
      drc_pkg::S_C_RD: begin
        if (i_q >= cnt_q) begin
          cnt_d   = j_q;
          state_d = drc_pkg::S_DONE;
        end else begin
          ram_raddr_o = i_q[AW-1:0];
          state_d     = drc_pkg::S_C_CHK;
        end
      end
      drc_pkg::S_C_CHK: begin
        if (!geo.tiny) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = j_q[AW-1:0];
          ram_wdata_o = ram_rdata_i;
          j_d         = j_q + CW'(1);
        end
        i_d     = i_q + CW'(1);
        state_d = drc_pkg::S_C_RD;
      end
      drc_pkg::S_DONE: begin
        if (out_free) begin
          post        = 1'b1;
          post_w.kind = mark_q ? drc_pkg::K_STORED : drc_pkg::K_OPTIMIZED;
          state_d     = drc_pkg::S_IDLE;
        end
      end
      // flush: j holds the number of words to emit
      drc_pkg::S_F_RD: begin
        ram_raddr_o = i_q[AW-1:0];
        state_d     = drc_pkg::S_F_OUT;
      end
      drc_pkg::S_F_OUT: begin
        ram_raddr_o = i_q[AW-1:0];
        if (out_free) begin
          post                = 1'b1;
          post_w.kind         = drc_pkg::K_REGION;
          post_w.out_left_x   = ram_rdata_i.x1;
          post_w.out_top_y    = ram_rdata_i.y1;
          post_w.out_right_x  = ram_rdata_i.x2;
          post_w.out_bottom_y = ram_rdata_i.y2;
          post_w.last         = (i_q + CW'(1) == j_q);
          i_d                 = i_q + CW'(1);
          state_d = post_w.last ? drc_pkg::S_IDLE : drc_pkg::S_F_RD;
        end
      end
      default: begin
        state_d = drc_pkg::S_IDLE;
      end
    endcase

    // output word register
    out_d = out_q;
    if (post) begin
      out_valid_d = 1'b1;
      out_d       = post_w;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

endmodule

FILE: src/dirty_rectangle_coalescer.sv
// Dirty rectangle coalescer: one item at a time through a store sequencer.
// Plain mark, dropped mark, flush held/empty and ignored items: word on the accepting edge.
// Optimize pass: entry i is read and latched, each candidate j read and compared,
// merges shift later entries down, then compaction drops tiny boxes, all through
// the single read port. Flush: each word is read, then posted unless output stalls.
// Reset clears counters and flush time, restores config defaults; store kept.
`timescale 1ns / 1ps
module dirty_rectangle_coalescer #(
  parameter int MAX_REGIONS = drc_pkg::MAX_REGIONS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [drc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [drc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  drc_pkg::in_t                     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output drc_pkg::out_t                    out_data_o
);

  localparam int AW = $clog2(MAX_REGIONS);

  drc_pkg::cfg_t  cfg_q;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  drc_pkg::rect_t ram_wdata, ram_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pr_en  <= 1'b1;
      cfg_q.bat_en <= 1'b1;
      cfg_q.ivl    <= drc_pkg::IVL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        drc_pkg::REG_PR_EN:  cfg_q.pr_en  <= cfg_data_i[0];
        drc_pkg::REG_BAT_EN: cfg_q.bat_en <= cfg_data_i[0];
        drc_pkg::REG_IVL:    cfg_q.ivl    <= cfg_data_i[drc_pkg::IVL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  drc_ram #(
    .WIDTH($bits(drc_pkg::rect_t)),
    .DEPTH(MAX_REGIONS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  drc_seq #(
    .MAX_REGIONS(MAX_REGIONS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata)
  );

endmodule

FILE: verif/dirty_rectangle_coalescer_tb.sv
// self-checking testbench for the dirty rectangle coalescer
`timescale 1ns / 1ps
module dirty_rectangle_coalescer_tb;

  localparam int STORE_DEPTH = drc_pkg::MAX_REGIONS_DEF;
  localparam int IDLE_LIMIT  = 1000000;

  typedef struct {
    int x1;
    int y1;
    int x2;
    int y2;
  } box_t;

  typedef struct {
    drc_pkg::in_t w;
    bit           drain;
  } pend_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [drc_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [drc_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  drc_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  drc_pkg::out_t out_data_o;

  dirty_rectangle_coalescer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // predictor state
  box_t        rect_store[STORE_DEPTH];
  int          rect_count = 0;
  logic [31:0] flush_stamp = '0;
  logic [31:0] mark_total = '0;
  logic        refresh_on = 1'b1;
  logic        batching_on = 1'b1;
  logic [9:0]  flush_gap = drc_pkg::IVL_RESET;

  pend_t         pending_words[$];
  drc_pkg::out_t expected_words[$];
  int    idle_pct = 0;
  int    stall_pct = 0;
  bit    word_taken = 0;
  int    mismatches = 0;
  int    quiet_cycles = 0;
  int    clock_ms = 100;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit boxes_touch(box_t a, box_t b);
    return !(a.x2 < b.x1 || b.x2 < a.x1 || a.y2 < b.y1 || b.y2 < a.y1);
  endfunction

  function automatic bit box_too_small(box_t r);
    longint w;
    longint h;
    w = longint'(r.x2) - r.x1 + 1;
    h = longint'(r.y2) - r.y1 + 1;
    if (w == 0 || h == 0) return 1;
    if ((w < 0) != (h < 0)) return 1;
    return (w * h) < drc_pkg::MIN_AREA;
  endfunction

  // merge first overlapping pairs into bounding boxes, then prune tiny boxes
  function automatic void coalesce_store();
    bit merged;
    int n;
    merged = 1;
    while (merged && rect_count > 1) begin
      merged = 0;
      for (int i = 0; i + 1 < rect_count && !merged; i++) begin
        for (int j = i + 1; j < rect_count && !merged; j++) begin
          if (boxes_touch(rect_store[i], rect_store[j])) begin
            if (rect_store[j].x1 < rect_store[i].x1) rect_store[i].x1 = rect_store[j].x1;
            if (rect_store[j].y1 < rect_store[i].y1) rect_store[i].y1 = rect_store[j].y1;
            if (rect_store[j].x2 > rect_store[i].x2) rect_store[i].x2 = rect_store[j].x2;
            if (rect_store[j].y2 > rect_store[i].y2) rect_store[i].y2 = rect_store[j].y2;
            for (int k = j; k + 1 < rect_count; k++) rect_store[k] = rect_store[k + 1];
            rect_count--;
            merged = 1;
          end
        end
      end
    end
    n = 0;
    for (int i = 0; i < rect_count; i++) begin
      if (!box_too_small(rect_store[i])) begin
        rect_store[n] = rect_store[i];
        n++;
      end
    end
    rect_count = n;
  endfunction

  function automatic void push_status(drc_pkg::kind_e k);
    drc_pkg::out_t o;
    o = '0;
    o.kind = k;
    o.stored_count = drc_pkg::CNT_OUT_W'(rect_count);
    o.marked_total = mark_total;
    o.last = 1'b1;
    expected_words.insert(expected_words.size(), o);
  endfunction

  // expected words for one accepted input word
  function automatic void predict_word(drc_pkg::in_t w);
    box_t b;
    drc_pkg::out_t o;
    int n;
    case (w.op)
      drc_pkg::OP_MARK: begin
        if (!refresh_on) push_status(drc_pkg::K_IGNORED);
        else if (rect_count >= STORE_DEPTH) push_status(drc_pkg::K_DROPPED);
        else begin
          b.x1 = w.left_x;
          b.y1 = w.top_y;
          b.x2 = w.right_x;
          b.y2 = w.bottom_y;
          rect_store[rect_count] = b;
          rect_count++;
          mark_total++;
          if (rect_count > drc_pkg::OPT_THRESHOLD) coalesce_store();
          push_status(drc_pkg::K_STORED);
        end
      end
      drc_pkg::OP_OPTIMIZE: begin
        coalesce_store();
        push_status(drc_pkg::K_OPTIMIZED);
      end
      drc_pkg::OP_FLUSH: begin
        if (rect_count == 0) push_status(drc_pkg::K_EMPTY);
        else if (batching_on && (w.now_ms - flush_stamp) < 32'(flush_gap))
          push_status(drc_pkg::K_HELD);
        else begin
          n = rect_count;
          rect_count = 0;
          flush_stamp = w.now_ms;
          for (int i = 0; i < n; i++) begin
            o = '0;
            o.kind = drc_pkg::K_REGION;
            o.out_left_x = drc_pkg::COORD_BITS'(rect_store[i].x1);
            o.out_top_y = drc_pkg::COORD_BITS'(rect_store[i].y1);
            o.out_right_x = drc_pkg::COORD_BITS'(rect_store[i].x2);
            o.out_bottom_y = drc_pkg::COORD_BITS'(rect_store[i].y2);
            o.stored_count = '0;
            o.marked_total = mark_total;
            o.last = (i + 1 == n);
            expected_words.insert(expected_words.size(), o);
          end
        end
      end
      default: push_status(drc_pkg::K_IGNORED);
    endcase
  endfunction

  // input driver, changes on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || word_taken) begin
        word_taken = 0;
        if (pending_words.size() > 0 &&
            !(pending_words[0].drain && expected_words.size() != 0) &&
            $urandom_range(99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_words[0].w;
          void'(pending_words.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor, checker and watchdog on the rising edge
  always @(posedge clk_i) begin
    drc_pkg::out_t exp_w;
    if (rst_ni) begin
      quiet_cycles++;
      if (out_valid_o && !out_stall_i) begin
        quiet_cycles = 0;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %p", out_data_o);
        end else begin
          exp_w = expected_words.pop_front();
          if (out_data_o !== exp_w) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p got %p", exp_w, out_data_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        quiet_cycles = 0;
        word_taken = 1;
        predict_word(in_data_i);
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("dirty_rectangle_coalescer_tb failed");
        $finish;
      end
    end
  end

  function automatic drc_pkg::in_t mark_word(int x1, int y1, int x2, int y2);
    drc_pkg::in_t w;
    w = '0;
    w.op = drc_pkg::OP_MARK;
    w.left_x = drc_pkg::COORD_BITS'(x1);
    w.top_y = drc_pkg::COORD_BITS'(y1);
    w.right_x = drc_pkg::COORD_BITS'(x2);
    w.bottom_y = drc_pkg::COORD_BITS'(y2);
    w.now_ms = $urandom;
    return w;
  endfunction

  function automatic drc_pkg::in_t op_word(drc_pkg::op_e op, logic [31:0] now);
    drc_pkg::in_t w;
    w = '0;
    w.op = op;
    w.now_ms = now;
    return w;
  endfunction

  function automatic void queue_word(drc_pkg::in_t w, bit drain = 0);
    pend_t p;
    p.w = w;
    p.drain = drain;
    pending_words.insert(pending_words.size(), p);
  endfunction

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || expected_words.size() != 0);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(drc_pkg::reg_idx_e idx, int value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= drc_pkg::CFG_DATA_W'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      drc_pkg::REG_PR_EN:  refresh_on = value[0];
      drc_pkg::REG_BAT_EN: batching_on = value[0];
      default:             flush_gap = value[9:0];
    endcase
  endtask

  // mostly local marks with flushes and optimizes, plus noise
  task automatic queue_random(int count);
    int r;
    int x;
    int y;
    drc_pkg::in_t w;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      x = $urandom_range(300) - 150;
      y = $urandom_range(300) - 150;
      if (r < 55) begin
        if ($urandom_range(9) == 0)
          queue_word(mark_word(x, y, x - $urandom_range(30), y - $urandom_range(30)));
        else
          queue_word(mark_word(x, y, x + $urandom_range(40), y + $urandom_range(40)));
      end else if (r < 60) begin
        queue_word(mark_word($urandom, $urandom, $urandom, $urandom));
      end else if (r < 70) begin
        queue_word(op_word(drc_pkg::OP_OPTIMIZE, $urandom));
      end else if (r < 90) begin
        clock_ms += $urandom_range(40);
        queue_word(op_word(drc_pkg::OP_FLUSH, clock_ms));
      end else if (r < 96) begin
        queue_word(op_word(drc_pkg::OP_FLUSH, $urandom));
      end else begin
        w = mark_word($urandom, $urandom, $urandom, $urandom);
        w.op = drc_pkg::OP_NONE;
        queue_word(w);
      end
    end
  endtask

  // disjoint tiles fill the store past the auto-optimize threshold
  task automatic queue_tiles(int count);
    for (int i = 0; i < count; i++)
      queue_word(mark_word(1000 + (i % 8) * 20, 1000 + (i / 8) * 20,
                           1011 + (i % 8) * 20, 1011 + (i / 8) * 20));
    clock_ms += 2000;
    queue_word(op_word(drc_pkg::OP_FLUSH, clock_ms));
  endtask

  initial begin
    drc_pkg::in_t w;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, inverted and tiny boxes, held and empty flushes
    queue_word(op_word(drc_pkg::OP_FLUSH, 32'd5));
    queue_word(mark_word(-32768, -32768, 32767, 32767));
    queue_word(mark_word(10, 10, 5, 50));
    queue_word(mark_word(50, 50, 30, 30));
    queue_word(mark_word(0, 0, 3, 3));
    queue_word(mark_word(100, 100, 200, 200));
    queue_word(op_word(drc_pkg::OP_OPTIMIZE, 32'd0));
    queue_word(mark_word(-1, -1, -1, -1));
    queue_word(mark_word(300, 300, 250, 250));
    queue_word(mark_word(-32768, 0, -32700, 10));
    queue_word(op_word(drc_pkg::OP_FLUSH, 32'd10));
    queue_word(op_word(drc_pkg::OP_FLUSH, 32'd30));
    w = mark_word(-1, -1, -1, -1);
    w.op = drc_pkg::OP_NONE;
    w.now_ms = '1;
    queue_word(w);
    queue_word(mark_word(0, 0, 20, 20));
    queue_word(op_word(drc_pkg::OP_FLUSH, 32'hffff_ffff));
    wait_idle();
    write_reg(drc_pkg::REG_PR_EN, 0);
    queue_word(mark_word(0, 0, 50, 50));
    queue_word(op_word(drc_pkg::OP_FLUSH, 32'd0));
    wait_idle();
    write_reg(drc_pkg::REG_PR_EN, 1);
    write_reg(drc_pkg::REG_IVL, 0);
    queue_word(mark_word(0, 0, 50, 50));
    queue_word(op_word(drc_pkg::OP_FLUSH, 32'hffff_ffff));
    queue_word(mark_word(0, 0, 50, 50));
    queue_word(op_word(drc_pkg::OP_FLUSH, 32'hffff_ffff));
    wait_idle();

    // random phases, each with its own idle and stall mix and register setting
    write_reg(drc_pkg::REG_BAT_EN, 0);
    write_reg(drc_pkg::REG_IVL, 1000);
    queue_random(40);
    queue_tiles(56);
    wait_idle();

    idle_pct = 64;
    write_reg(drc_pkg::REG_BAT_EN, 1);
    write_reg(drc_pkg::REG_IVL, 1);
    queue_random(20);
    queue_word(op_word(drc_pkg::OP_OPTIMIZE, 32'd0), 1);
    queue_random(20);
    wait_idle();

    idle_pct = 0;
    stall_pct = 64;
    write_reg(drc_pkg::REG_IVL, 1023);
    queue_random(25);
    clock_ms += 5000;
    queue_random(20);
    wait_idle();

    idle_pct = 36;
    stall_pct = 36;
    write_reg(drc_pkg::REG_IVL, 22);
    queue_random(25);
    queue_tiles(52);
    wait_idle();

    if (mismatches == 0) begin
      $display("dirty_rectangle_coalescer_tb passed");
    end else begin
      $display("dirty_rectangle_coalescer_tb failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/drc_pkg.sv
src/drc_ram.sv
src/drc_geom.sv
src/drc_seq.sv
src/dirty_rectangle_coalescer.sv
verif/dirty_rectangle_coalescer_tb.sv
